>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion wrappers, clocked on aclk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GFBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GFBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/gfba_pkg.sv
// ----------------------------------------------------------------------------
// gfba_pkg
// shared types and codes of the grouped free block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package gfba_pkg;

    localparam int FIELD_W = 10;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_FORMAT = 2'd2,
        OP_NONE   = 2'd3
    } gfba_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ALLOC_RD,
        ST_LOAD,
        ST_LOAD_TAIL,
        ST_SPILL,
        ST_SPILL_TAIL,
        ST_PUSH,
        ST_FMT_CHECK,
        ST_FMT_BASE,
        ST_FMT_ROW,
        ST_FMT_FILL,
        ST_FINISH
    } gfba_state_t;

    typedef struct packed {
        logic               status;
        logic [FIELD_W-1:0] granted_block;
        logic [FIELD_W-1:0] free_count;
    } gfba_result_t;

endpackage

`default_nettype wire

>>> rtl/core/grouped_free_block_allocator.sv
// Path from accept to result: refused or unused words go dispatch then finish; a plain
// allocate reads the group ram, a plain free pushes; an allocate that reloads or a free that
// spills moves a group word by word through the link ram; a format writes one link row per
// group, then fills the group ram. One word in flight: the sequencer goes back to idle as
// the result is registered, and a finished result waits while the output slot is busy.
// Reset clears the sequencer, group count and free count; link rows are not cleared.
// ----------------------------------------------------------------------------
// grouped_free_block_allocator
// disk block allocator over a grouped free list kept in internal link ram
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module grouped_free_block_allocator #(
    parameter int BLOCK_COUNT = 1024,
    parameter int GROUP_WORDS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic [gfba_pkg::FIELD_W-1:0] s_freed_block,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_status,
    output logic [gfba_pkg::FIELD_W-1:0] m_granted_block,
    output logic [gfba_pkg::FIELD_W-1:0] m_free_count
);

    import gfba_pkg::*;

    logic         ctrl_ready;
    logic         done;
    logic         out_free;
    gfba_result_t result;

    logic               m_valid_reg;
    logic               m_status_reg;
    logic [FIELD_W-1:0] m_granted_reg;
    logic [FIELD_W-1:0] m_free_reg;

    // output slot frees up in the same cycle it is taken
    assign out_free = !m_valid_reg || m_ready;

    gfba_ctrl #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .GROUP_WORDS (GROUP_WORDS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_valid && ctrl_ready),
        .opcode      (s_opcode),
        .freed_block (s_freed_block),
        .out_free    (out_free),
        .ready       (ctrl_ready),
        .done        (done),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_status_reg  <= result.status;
            m_granted_reg <= result.granted_block;
            m_free_reg    <= result.free_count;
        end
    end

    assign s_ready         = ctrl_ready;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_block = m_granted_reg;
    assign m_free_count    = m_free_reg;

    `GFBA_ASSERT_IMP(a_done_slot_free, done, (!m_valid_reg || m_ready), "result finished while output slot busy")
    `GFBA_ASSERT_NXT(a_busy_after_accept, (s_valid && s_ready), (!s_ready), "new word taken while one in flight")
    `GFBA_ASSERT_IMP(a_refused_no_grant, (m_valid && m_status), (m_granted_block == '0), "refused allocate carries a block")

endmodule

`default_nettype wire

>>> rtl/core/gfba_ram.sv
// ----------------------------------------------------------------------------
// gfba_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module gfba_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 10
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/gfba_ctrl.sv
// ----------------------------------------------------------------------------
// gfba_ctrl
// sequencer and shared row address unit: pops, pushes, group spill and
// reload through the link ram, and the format sweep
// ----------------------------------------------------------------------------
`default_nettype none

module gfba_ctrl #(
    parameter int BLOCK_COUNT = 1024,
    parameter int GROUP_WORDS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [1:0]                    opcode,
    input  logic [gfba_pkg::FIELD_W-1:0]  freed_block,
    input  logic                          out_free,
    output logic                          ready,
    output logic                          done,
    output gfba_pkg::gfba_result_t        result
);

    import gfba_pkg::*;

    localparam int BW    = $clog2(BLOCK_COUNT);
    localparam int CW    = $clog2(GROUP_WORDS);
    localparam int LW    = (BW > CW) ? BW : CW;
    localparam int LDEP  = BLOCK_COUNT * GROUP_WORDS;
    localparam int AW    = $clog2(LDEP);
    localparam int TOP   = GROUP_WORDS - 1;

    gfba_state_t   state_reg, state_next;
    gfba_op_t      op_reg, op_next;
    logic [BW-1:0] blk_reg, blk_next;
    logic          in_range_reg, in_range_next;
    logic [CW-1:0] count_reg, count_next;
    logic [BW-1:0] free_reg, free_next;
    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pidx_reg, pidx_next;
    logic          pvalid_reg, pvalid_next;
    logic [BW-1:0] s_reg, s_next;
    logic [BW-1:0] granted_reg, granted_next;
    logic          status_reg, status_next;

    // ram ports
    logic          grp_we;
    logic [CW-1:0] grp_waddr, grp_raddr;
    logic [BW-1:0] grp_wdata, grp_rdata;
    logic          link_we;
    logic [LW-1:0] link_wdata, link_rdata;

    // shared arithmetic
    logic [CW-1:0] sel_idx;
    logic [AW-1:0] row_addr;
    logic [BW-1:0] mul_in;
    logic [AW-1:0] base_prod;
    logic [BW-1:0] fmt_val;
    logic [BW:0]   fmt_end;
    logic          fmt_more;
    logic [CW-1:0] ld_count;
    logic [CW-1:0] count_inc;
    logic          grp_top;
    logic          last_idx;
    logic          grant_in_range;
    logic          refuse;

    assign sel_idx   = (state_reg == ST_SPILL || state_reg == ST_SPILL_TAIL) ? pidx_reg : idx_reg;
    assign row_addr  = base_reg + AW'(sel_idx);
    assign mul_in    = (state_reg == ST_ALLOC_RD) ? grp_rdata : blk_reg;
    assign base_prod = AW'(mul_in) * AW'(GROUP_WORDS);
    assign fmt_val   = s_reg + BW'(idx_reg) - BW'(1);
    assign fmt_end   = {1'b0, s_reg} + (BW+1)'(TOP);
    assign fmt_more  = fmt_end < (BW+1)'(BLOCK_COUNT);
    assign ld_count  = (link_rdata > LW'(TOP)) ? CW'(TOP) : CW'(link_rdata);
    assign count_inc = count_reg + CW'(1);
    assign grp_top   = count_reg >= CW'(TOP);
    assign last_idx  = idx_reg == CW'(TOP);
    assign grant_in_range = {1'b0, grp_rdata} < (BW+1)'(BLOCK_COUNT);
    assign refuse    = (free_reg == '0) || (count_reg == '0) || (count_reg > CW'(TOP));

    gfba_ram #(
        .DEPTH (GROUP_WORDS),
        .WIDTH (BW)
    ) u_group_ram (
        .aclk  (aclk),
        .we    (grp_we),
        .waddr (grp_waddr),
        .wdata (grp_wdata),
        .raddr (grp_raddr),
        .rdata (grp_rdata)
    );

    gfba_ram #(
        .DEPTH (LDEP),
        .WIDTH (LW)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (row_addr),
        .wdata (link_wdata),
        .raddr (row_addr),
        .rdata (link_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                unique case (op_reg)
                    OP_ALLOC: begin
                        state_next = refuse ? ST_FINISH : ST_ALLOC_RD;
                    end
                    OP_FREE: begin
                        priority if (!in_range_reg) state_next = ST_FINISH;
                        else if (grp_top)           state_next = ST_SPILL;
                        else                        state_next = ST_PUSH;
                    end
                    OP_FORMAT: state_next = ST_FMT_CHECK;
                    OP_NONE:   state_next = ST_FINISH;
                endcase
            end
            ST_ALLOC_RD: begin
                state_next = (count_reg == CW'(1) && grant_in_range) ? ST_LOAD : ST_FINISH;
            end
            ST_LOAD:       if (last_idx) state_next = ST_LOAD_TAIL;
            ST_LOAD_TAIL:  state_next = ST_FINISH;
            ST_SPILL:      if (last_idx) state_next = ST_SPILL_TAIL;
            ST_SPILL_TAIL: state_next = ST_PUSH;
            ST_PUSH:       state_next = ST_FINISH;
            ST_FMT_CHECK:  state_next = fmt_more ? ST_FMT_BASE : ST_FMT_FILL;
            ST_FMT_BASE:   state_next = ST_FMT_ROW;
            ST_FMT_ROW:    if (last_idx) state_next = ST_FMT_CHECK;
            ST_FMT_FILL:   if (last_idx) state_next = ST_FINISH;
            ST_FINISH:     if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        op_next       = op_reg;
        blk_next      = blk_reg;
        in_range_next = in_range_reg;
        count_next    = count_reg;
        free_next     = free_reg;
        base_next     = base_reg;
        idx_next      = idx_reg;
        pidx_next     = pidx_reg;
        pvalid_next   = pvalid_reg;
        s_next        = s_reg;
        granted_next  = granted_reg;
        status_next   = status_reg;
        grp_we        = 1'b0;
        grp_waddr     = idx_reg;
        grp_wdata     = fmt_val;
        grp_raddr     = count_reg;
        link_we       = 1'b0;
        link_wdata    = LW'(fmt_val);

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    op_next       = gfba_op_t'(opcode);
                    blk_next      = BW'(freed_block);
                    in_range_next = 17'(freed_block) < 17'(BLOCK_COUNT);
                    status_next   = 1'b0;
                    granted_next  = '0;
                end
            end
            ST_DISPATCH: begin
                unique case (op_reg)
                    OP_ALLOC: begin
                        if (refuse) status_next = 1'b1;
                    end
                    OP_FREE: begin
                        if (in_range_reg && grp_top) begin
                            base_next   = base_prod;
                            idx_next    = '0;
                            pvalid_next = 1'b0;
                        end
                    end
                    OP_FORMAT: s_next = '0;
                    OP_NONE: begin
                    end
                endcase
            end
            ST_ALLOC_RD: begin
                granted_next = grp_rdata;
                free_next    = free_reg - BW'(1);
                if (count_reg == CW'(1)) begin
                    if (grant_in_range) begin
                        base_next   = base_prod;
                        idx_next    = '0;
                        pvalid_next = 1'b0;
                    end else begin
                        count_next = '0;
                    end
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            ST_LOAD, ST_LOAD_TAIL: begin
                // read word idx, take in word pidx from the cycle before
                pvalid_next = (state_reg == ST_LOAD);
                pidx_next   = idx_reg;
                idx_next    = idx_reg + CW'(1);
                if (pvalid_reg) begin
                    if (pidx_reg == '0) begin
                        count_next = ld_count;
                    end else begin
                        grp_we    = 1'b1;
                        grp_waddr = pidx_reg;
                        grp_wdata = BW'(link_rdata);
                    end
                end
            end
            ST_SPILL, ST_SPILL_TAIL: begin
                grp_raddr   = idx_reg;
                pvalid_next = (state_reg == ST_SPILL);
                pidx_next   = idx_reg;
                idx_next    = idx_reg + CW'(1);
                if (pvalid_reg) begin
                    link_we    = 1'b1;
                    link_wdata = (pidx_reg == '0) ? LW'(count_reg) : LW'(grp_rdata);
                end
                if (state_reg == ST_SPILL_TAIL) count_next = '0;
            end
            ST_PUSH: begin
                grp_we     = 1'b1;
                grp_waddr  = count_inc;
                grp_wdata  = blk_reg;
                count_next = count_inc;
                if (free_reg < BW'(BLOCK_COUNT - 1)) free_next = free_reg + BW'(1);
            end
            ST_FMT_CHECK: begin
                idx_next = '0;
                if (fmt_more) blk_next = BW'(fmt_end);
            end
            ST_FMT_BASE: begin
                base_next = base_prod;
            end
            ST_FMT_ROW: begin
                // row of the link block holds the group that starts at s
                link_we    = 1'b1;
                link_wdata = (idx_reg == '0) ? LW'(TOP) : LW'(fmt_val);
                idx_next   = idx_reg + CW'(1);
                if (last_idx) s_next = blk_reg;
            end
            ST_FMT_FILL: begin
                grp_we   = 1'b1;
                idx_next = idx_reg + CW'(1);
                if (last_idx) begin
                    count_next = CW'((BW+1)'(BLOCK_COUNT) - {1'b0, s_reg});
                    free_next  = BW'(BLOCK_COUNT - 1);
                end
            end
            ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // handshake and result
    always_comb begin
        ready                = (state_reg == ST_IDLE);
        done                 = (state_reg == ST_FINISH) && out_free;
        result.status        = status_reg;
        result.granted_block = FIELD_W'(granted_reg);
        result.free_count    = FIELD_W'(free_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            free_reg   <= '0;
            pvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            free_reg   <= free_next;
            pvalid_reg <= pvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        blk_reg      <= blk_next;
        in_range_reg <= in_range_next;
        base_reg     <= base_next;
        idx_reg      <= idx_next;
        pidx_reg     <= pidx_next;
        s_reg        <= s_next;
        granted_reg  <= granted_next;
        status_reg   <= status_next;
    end

endmodule

`default_nettype wire

>>> dv/tb_grouped_free_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_grouped_free_block_allocator
// Self-checking bench for the grouped free block allocator. A queue of
// allocate, free, format and unused-opcode words is planned up front on a
// shadow copy of the free list, so that no group is ever reloaded from a
// link row that was never written. A second copy predicts every accepted
// word and each result word is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_grouped_free_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import gfba_pkg::*;

    localparam int BLOCK_COUNT = 1024;
    localparam int GROUP_WORDS = 16;
    localparam int TOP         = GROUP_WORDS - 1;
    localparam int ROW_WORDS   = BLOCK_COUNT * GROUP_WORDS;

    // shadow copies of the free list: one for planning, one for checking
    localparam int PLAN = 0;
    localparam int LIVE = 1;

    localparam int ITEM_TARGET  = 600;
    localparam int TAIL_ITEMS   = 60;
    localparam int SYNC_AT      = 300;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        gfba_op_t           op;
        logic [FIELD_W-1:0] blk;
        bit                 sync;
    } pool_request_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [1:0]         s_opcode      = '0;
    logic [FIELD_W-1:0] s_freed_block = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic               m_status;
    logic [FIELD_W-1:0] m_granted_block;
    logic [FIELD_W-1:0] m_free_count;

    logic [FIELD_W-1:0] link_mem    [2][ROW_WORDS];
    bit                 row_written [2][BLOCK_COUNT];
    logic [FIELD_W-1:0] grp_slot    [2][GROUP_WORDS];
    int unsigned        grp_fill    [2];
    int unsigned        pool_left   [2];

    pool_request_t      queued_requests[$];
    gfba_result_t       due_replies[$];
    logic [FIELD_W-1:0] held_blocks[$];

    pool_request_t      req;
    gfba_result_t       want;
    int                 planned_cnt = 0;
    bit                 sync_placed = 1'b0;
    int                 gap_left    = 0;
    int                 stall_left  = 0;
    int                 hold_left   = 0;
    int                 replies_seen = 0;
    int                 fail_cnt    = 0;
    int                 cycle_cnt   = 0;
    int                 n_words = 0, n_grant = 0, n_refuse = 0, n_free = 0;
    int                 n_format = 0, n_reload = 0, n_spill = 0, n_hold = 0;

    grouped_free_block_allocator #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .GROUP_WORDS (GROUP_WORDS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_freed_block   (s_freed_block),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_block (m_granted_block),
        .m_free_count    (m_free_count)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // free list model
    // ------------------------------------------------------------------
    function automatic void group_clear(int m);
        for (int w = 0; w < GROUP_WORDS; w++) grp_slot[m][w] = '0;
    endfunction

    function automatic void group_save(int m, logic [FIELD_W-1:0] blk);
        int base;
        base = int'(blk) * GROUP_WORDS;
        link_mem[m][base] = FIELD_W'(grp_fill[m]);
        for (int w = 1; w < GROUP_WORDS; w++) link_mem[m][base + w] = grp_slot[m][w];
        row_written[m][blk] = 1'b1;
    endfunction

    function automatic void group_load(int m, logic [FIELD_W-1:0] blk);
        int base;
        base = int'(blk) * GROUP_WORDS;
        grp_fill[m] = 32'(link_mem[m][base]);
        if (grp_fill[m] > TOP) grp_fill[m] = TOP;
        grp_slot[m][0] = '0;
        for (int w = 1; w < GROUP_WORDS; w++) grp_slot[m][w] = link_mem[m][base + w];
    endfunction

    function automatic void pool_format(int m);
        int unsigned left;
        int unsigned take;
        int          nxt;
        left = BLOCK_COUNT - 1;
        nxt  = 1;
        group_clear(m);
        // first group keeps the end-of-chain link in entry 1
        take = (left < GROUP_WORDS - 2) ? left : GROUP_WORDS - 2;
        for (int k = 0; k < take; k++) begin
            grp_slot[m][2 + k] = FIELD_W'(nxt);
            nxt++;
        end
        grp_fill[m] = 1 + take;
        left -= take;
        while (left > 0) begin
            group_save(m, FIELD_W'(nxt));
            group_clear(m);
            take = (left < TOP) ? left : TOP;
            for (int k = 0; k < take; k++) begin
                grp_slot[m][1 + k] = FIELD_W'(nxt);
                nxt++;
            end
            grp_fill[m] = take;
            left -= take;
        end
        pool_left[m] = BLOCK_COUNT - 1;
    endfunction

    function automatic gfba_result_t pool_step(int m, gfba_op_t op, logic [FIELD_W-1:0] blk);
        gfba_result_t r;
        r = '0;
        case (op)
            OP_ALLOC: begin
                if (pool_left[m] == 0 || grp_fill[m] == 0) begin
                    r.status = 1'b1;
                    if (m == LIVE) n_refuse++;
                end else begin
                    r.granted_block = grp_slot[m][grp_fill[m]];
                    if (grp_fill[m] == 1) begin
                        // last entry is the link to the next group
                        group_load(m, r.granted_block);
                        if (m == LIVE) n_reload++;
                    end else begin
                        grp_fill[m]--;
                    end
                    pool_left[m]--;
                    if (m == LIVE) n_grant++;
                end
            end
            OP_FREE: begin
                // every 10-bit block number lies inside the disk
                if (grp_fill[m] >= TOP) begin
                    group_save(m, blk);
                    grp_fill[m] = 0;
                    if (m == LIVE) n_spill++;
                end
                grp_fill[m]++;
                grp_slot[m][grp_fill[m]] = blk;
                if (pool_left[m] < BLOCK_COUNT - 1) pool_left[m]++;
                if (m == LIVE) n_free++;
            end
            OP_FORMAT: begin
                pool_format(m);
                if (m == LIVE) n_format++;
            end
            default: ;
        endcase
        r.free_count = FIELD_W'(pool_left[m]);
        return r;
    endfunction

    // an allocate must never reload a group from a row that was never written
    function automatic bit reload_safe(int m);
        return !(pool_left[m] != 0 && grp_fill[m] == 1 && !row_written[m][grp_slot[m][1]]);
    endfunction

    // ------------------------------------------------------------------
    // stimulus planning
    // ------------------------------------------------------------------
    function automatic logic [FIELD_W-1:0] spare_block();
        int                 idx;
        logic [FIELD_W-1:0] b;
        // mostly give back blocks really held, sometimes any block
        if (held_blocks.size() != 0 && $urandom_range(0, 7) != 0) begin
            idx = $urandom_range(0, held_blocks.size() - 1);
            b = held_blocks[idx];
            held_blocks.delete(idx);
        end else begin
            b = FIELD_W'($urandom_range(0, BLOCK_COUNT - 1));
        end
        return b;
    endfunction

    function automatic logic [FIELD_W-1:0] any_block();
        return FIELD_W'($urandom);
    endfunction

    task automatic queue_request(gfba_op_t op, logic [FIELD_W-1:0] blk);
        pool_request_t q;
        gfba_result_t  r;
        if (op == OP_ALLOC && !reload_safe(PLAN)) begin
            op  = OP_FREE;
            blk = spare_block();
        end
        r = pool_step(PLAN, op, blk);
        if (op == OP_ALLOC && !r.status) held_blocks.insert(held_blocks.size(), r.granted_block);
        if (op == OP_FORMAT) held_blocks.delete();
        if (op != OP_NONE) planned_cnt++;
        q.op   = op;
        q.blk  = blk;
        q.sync = !sync_placed && planned_cnt >= SYNC_AT;
        if (q.sync) sync_placed = 1'b1;
        queued_requests.insert(queued_requests.size(), q);
    endtask

    function automatic bit in_tail();
        return queued_requests.size() < TAIL_ITEMS;
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                due_replies.insert(due_replies.size(),
                                   pool_step(LIVE, gfba_op_t'(s_opcode), s_freed_block));
                n_words++;
                if (!in_tail() && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 11);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (queued_requests.size() == 0 ||
                             (queued_requests[0].sync && due_replies.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    req = queued_requests.pop_front();
                    s_valid       <= 1'b1;
                    s_opcode      <= req.op;
                    s_freed_block <= req.blk;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                replies_seen++;
                if (due_replies.size() == 0) begin
                    $error("unexpected word: status=%0d granted_block=%0d free_count=%0d",
                           m_status, m_granted_block, m_free_count);
                    fail_cnt++;
                end else begin
                    want = due_replies.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        fail_cnt++;
                    end
                    if (m_granted_block !== want.granted_block) begin
                        $error("granted_block: expected %0d, actual %0d",
                               want.granted_block, m_granted_block);
                        fail_cnt++;
                    end
                    if (m_free_count !== want.free_count) begin
                        $error("free_count: expected %0d, actual %0d",
                               want.free_count, m_free_count);
                        fail_cnt++;
                    end
                end
                // long hold-offs so the allocator backs up onto its input
                if (replies_seen == 200 || replies_seen == 420) begin
                    hold_left = LONG_HOLD;
                    n_hold++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!in_tail() && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 10);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("tb_grouped_free_block_allocator failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int                 pick;
        logic [FIELD_W-1:0] link;

        for (int m = 0; m < 2; m++) begin
            group_clear(m);
            grp_fill[m]  = 0;
            pool_left[m] = 0;
        end

        // before format: refused allocate, unused opcode, extremes, double free
        queue_request(OP_ALLOC, 10'd1023);
        queue_request(OP_NONE, 10'd1023);
        queue_request(OP_NONE, 10'd0);
        queue_request(OP_FREE, 10'd0);
        queue_request(OP_FREE, 10'd1023);
        queue_request(OP_FREE, 10'd1023);
        queue_request(OP_ALLOC, 10'd0);

        // fill the group, spill it into the link block's row, then drain to empty
        link = grp_slot[PLAN][1];
        while (grp_fill[PLAN] < TOP) queue_request(OP_FREE, FIELD_W'($urandom_range(1, 1022)));
        queue_request(OP_FREE, link);
        while (pool_left[PLAN] != 0) queue_request(OP_ALLOC, any_block());
        queue_request(OP_ALLOC, any_block());

        // format, free on a full pool saturates, allocate from the fresh chain
        queue_request(OP_FORMAT, 10'd0);
        queue_request(OP_FREE, 10'd512);
        queue_request(OP_ALLOC, 10'd1023);
        queue_request(OP_ALLOC, any_block());

        while (planned_cnt < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                queue_request(OP_FORMAT, any_block());
            end else if (pick < 40) begin
                repeat ($urandom_range(1, 48)) queue_request(OP_ALLOC, any_block());
            end else if (pick < 68) begin
                repeat ($urandom_range(1, 40)) queue_request(OP_FREE, spare_block());
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 24)) begin
                    if ($urandom_range(0, 1) != 0) queue_request(OP_ALLOC, any_block());
                    else queue_request(OP_FREE, spare_block());
                end
            end else begin
                repeat ($urandom_range(1, 3)) queue_request(OP_NONE, any_block());
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (queued_requests.size() != 0 || s_valid) @(posedge aclk);
        while (due_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d words: %0d grants, %0d refusals, %0d frees, %0d formats",
                 n_words, n_grant, n_refuse, n_free, n_format);
        $display("%0d group reloads, %0d group spills, %0d long receiver hold-offs",
                 n_reload, n_spill, n_hold);
        if (fail_cnt == 0) begin
            $display("tb_grouped_free_block_allocator passed");
        end else begin
            $display("tb_grouped_free_block_allocator failed");
        end
        $finish;
    end

endmodule
